### rtl/qie_pkg.sv
// Shared types, constants and the index hash for the QOI encoder.
// No dependencies; every other file in rtl/ imports this package.
package qie_pkg;

    localparam int QIE_COORD_BITS     = 16;
    localparam int QIE_HASH_BITS      = 6;
    localparam int QIE_PIXEL_BITS     = 24;
    localparam int QIE_CFG_INDEX_BITS = 4;
    localparam int QIE_DIM_BITS       = 16;

    // Configuration register indexes
    localparam logic [QIE_CFG_INDEX_BITS-1:0] QIE_REG_WIDTH  = 4'd0;
    localparam logic [QIE_CFG_INDEX_BITS-1:0] QIE_REG_HEIGHT = 4'd1;

    // Chunk opcodes
    localparam logic [7:0] QOI_OP_INDEX = 8'h00;
    localparam logic [7:0] QOI_OP_DIFF  = 8'h40;
    localparam logic [7:0] QOI_OP_LUMA  = 8'h80;
    localparam logic [7:0] QOI_OP_RUN   = 8'hC0;
    localparam logic [7:0] QOI_OP_RGB   = 8'hFE;

    localparam logic [5:0] QIE_RUN_LIMIT = 6'd62;

    // Byte work left for one pixel: header, run flush, chunk, end marker
    typedef struct packed {
        logic            hdr;
        logic            run;
        logic [7:0]      run_byte;
        logic [2:0]      chunk_len;
        logic [3:0][7:0] chunk;
        logic            tail;
    } qie_desc_t;

    // (3r + 5g + 7b + 11*255) mod 64; 11*255 mod 64 is 53
    function automatic logic [QIE_HASH_BITS-1:0] qie_hash(input logic [7:0] r,
                                                           input logic [7:0] g,
                                                           input logic [7:0] b);
        logic [11:0] sum;
        sum = 12'(r) * 12'd3 + 12'(g) * 12'd5 + 12'(b) * 12'd7 + 12'd53;
        return sum[QIE_HASH_BITS-1:0];
    endfunction

endpackage

### rtl/qie_index_ram.sv
// 64 x 24 color index memory, one write port, one registered read port.
// Depends on qie_pkg for the address and data widths.
module qie_index_ram (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [qie_pkg::QIE_HASH_BITS-1:0]  wr_addr,
    input  logic [qie_pkg::QIE_PIXEL_BITS-1:0] wr_data,
    input  logic                               rd_en,
    input  logic [qie_pkg::QIE_HASH_BITS-1:0]  rd_addr,
    output logic [qie_pkg::QIE_PIXEL_BITS-1:0] rd_data
);
    import qie_pkg::*;

    localparam int DEPTH = 1 << QIE_HASH_BITS;

    logic [QIE_PIXEL_BITS-1:0] mem [DEPTH];
    logic [QIE_PIXEL_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/qie_pixel_coder.sv
// Pixel stage: index lookup, run tracking, chunk choice and image position.
// Depends on qie_pkg; drives qie_index_ram and feeds qie_byte_sender.
module qie_pixel_coder #(
    parameter int COORD_BITS = qie_pkg::QIE_COORD_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pixel_valid,
    output logic                               pixel_stall,
    input  logic [7:0]                         red,
    input  logic [7:0]                         green,
    input  logic [7:0]                         blue,
    input  logic [qie_pkg::QIE_DIM_BITS-1:0]   width,
    input  logic [qie_pkg::QIE_DIM_BITS-1:0]   height,
    output logic                               rd_en,
    output logic [qie_pkg::QIE_HASH_BITS-1:0]  rd_addr,
    input  logic [qie_pkg::QIE_PIXEL_BITS-1:0] rd_data,
    output logic                               wr_en,
    output logic [qie_pkg::QIE_HASH_BITS-1:0]  wr_addr,
    output logic [qie_pkg::QIE_PIXEL_BITS-1:0] wr_data,
    output qie_pkg::qie_desc_t                 desc,
    output logic                               desc_push,
    input  logic                               desc_ready,
    output logic                               busy
);
    import qie_pkg::*;

    localparam int CMP_BITS = (COORD_BITS > QIE_DIM_BITS) ? COORD_BITS : QIE_DIM_BITS;
    localparam int DEPTH    = 1 << QIE_HASH_BITS;

    logic                      s1_valid_reg;
    logic [QIE_PIXEL_BITS-1:0] s1_px_reg;
    logic [QIE_HASH_BITS-1:0]  s1_hash_reg;
    logic                      fwd_hit_reg;
    logic [QIE_PIXEL_BITS-1:0] fwd_data_reg;

    logic [QIE_PIXEL_BITS-1:0] prev_reg;
    logic [QIE_PIXEL_BITS-1:0] prev_next;
    logic [5:0]                run_reg;
    logic [5:0]                run_next;
    logic [COORD_BITS-1:0]     col_reg;
    logic [COORD_BITS-1:0]     row_reg;
    logic [DEPTH-1:0]          entry_valid_reg;

    logic                      in_fire;
    logic                      fire;
    logic [QIE_HASH_BITS-1:0]  in_hash;
    logic [QIE_PIXEL_BITS-1:0] entry;
    logic [QIE_DIM_BITS-1:0]   w_m1;
    logic [QIE_DIM_BITS-1:0]   h_m1;
    logic                      row_end;
    logic                      last;
    logic                      hdr;
    logic                      same;
    logic                      hit;
    logic                      write;
    logic                      needs;
    logic [5:0]                run_inc;
    logic signed [7:0]         vr;
    logic signed [7:0]         vg;
    logic signed [7:0]         vb;
    logic signed [7:0]         vgr;
    logic signed [7:0]         vgb;

    assign in_hash     = qie_hash(red, green, blue);
    assign in_fire     = pixel_valid && !pixel_stall;
    assign rd_en       = in_fire;
    assign rd_addr     = in_hash;
    // Entry written by the pixel leaving this stage is not yet in the read data
    assign entry       = fwd_hit_reg ? fwd_data_reg : rd_data;

    always_comb
    begin
        w_m1    = (width  == '0) ? '0 : width  - QIE_DIM_BITS'(1);
        h_m1    = (height == '0) ? '0 : height - QIE_DIM_BITS'(1);
        row_end = CMP_BITS'(col_reg) >= CMP_BITS'(w_m1);
        last    = row_end && (CMP_BITS'(row_reg) >= CMP_BITS'(h_m1));
        hdr     = (col_reg == '0) && (row_reg == '0);
        same    = s1_px_reg == prev_reg;
        run_inc = run_reg + 6'd1;
        hit     = entry_valid_reg[s1_hash_reg] && (entry == s1_px_reg);

        vr  = s1_px_reg[23:16] - prev_reg[23:16];
        vg  = s1_px_reg[15:8]  - prev_reg[15:8];
        vb  = s1_px_reg[7:0]   - prev_reg[7:0];
        vgr = vr - vg;
        vgb = vb - vg;

        desc           = '0;
        desc.hdr       = hdr;
        desc.tail      = last;
        desc.run_byte  = QOI_OP_RUN | {2'b00, same ? run_reg : run_reg - 6'd1};
        write          = 1'b0;
        run_next       = run_reg;
        prev_next      = prev_reg;

        if (same)
        begin
            if ((run_inc == QIE_RUN_LIMIT) || last)
            begin
                desc.run = 1'b1;
                run_next = '0;
            end
            else
            begin
                run_next = run_inc;
            end
        end
        else
        begin
            desc.run  = run_reg != '0;
            run_next  = '0;
            prev_next = s1_px_reg;
            if (hit)
            begin
                desc.chunk_len = 3'd1;
                desc.chunk[0]  = QOI_OP_INDEX | {2'b00, s1_hash_reg};
            end
            else
            begin
                write = 1'b1;
                if ((vr >= -8'sd2) && (vr <= 8'sd1) && (vg >= -8'sd2) && (vg <= 8'sd1)
                    && (vb >= -8'sd2) && (vb <= 8'sd1))
                begin
                    // bias of 2 on a 2-bit field flips the top bit
                    desc.chunk_len = 3'd1;
                    desc.chunk[0]  = QOI_OP_DIFF | {2'b00, vr[1:0] ^ 2'b10,
                                                    vg[1:0] ^ 2'b10, vb[1:0] ^ 2'b10};
                end
                else if ((vg >= -8'sd32) && (vg <= 8'sd31) && (vgr >= -8'sd8)
                         && (vgr <= 8'sd7) && (vgb >= -8'sd8) && (vgb <= 8'sd7))
                begin
                    desc.chunk_len = 3'd2;
                    desc.chunk[0]  = QOI_OP_LUMA | {2'b00, vg[5:0] ^ 6'b100000};
                    desc.chunk[1]  = {vgr[3:0] ^ 4'b1000, vgb[3:0] ^ 4'b1000};
                end
                else
                begin
                    desc.chunk_len = 3'd4;
                    desc.chunk[0]  = QOI_OP_RGB;
                    desc.chunk[1]  = s1_px_reg[23:16];
                    desc.chunk[2]  = s1_px_reg[15:8];
                    desc.chunk[3]  = s1_px_reg[7:0];
                end
            end
        end

        needs = hdr || desc.run || (desc.chunk_len != '0) || last;
    end

    assign fire        = s1_valid_reg && (!needs || desc_ready);
    assign desc_push   = s1_valid_reg && needs && desc_ready;
    assign pixel_stall = s1_valid_reg && !fire;
    assign busy        = s1_valid_reg;
    assign wr_en       = fire && write;
    assign wr_addr     = s1_hash_reg;
    assign wr_data     = s1_px_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_px_reg    <= {red, green, blue};
            s1_hash_reg  <= in_hash;
            fwd_hit_reg  <= wr_en && (wr_addr == in_hash);
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg        <= '0;
            run_reg         <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            entry_valid_reg <= '0;
        end
        else if (fire)
        begin
            if (last)
            begin
                // image done: drop back to the start state
                prev_reg        <= '0;
                run_reg         <= '0;
                col_reg         <= '0;
                row_reg         <= '0;
                entry_valid_reg <= '0;
            end
            else
            begin
                prev_reg <= prev_next;
                run_reg  <= run_next;
                if (write)
                begin
                    entry_valid_reg[s1_hash_reg] <= 1'b1;
                end
                if (row_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + COORD_BITS'(1);
                end
                else
                begin
                    col_reg <= col_reg + COORD_BITS'(1);
                end
            end
        end
    end

endmodule

### rtl/qie_byte_sender.sv
// Byte serializer: walks one pixel's header, run, chunk and end marker bytes.
// Depends on qie_pkg for the work descriptor; fed by qie_pixel_coder.
module qie_byte_sender (
    input  logic                             clk,
    input  logic                             rst_n,
    input  qie_pkg::qie_desc_t               desc_in,
    input  logic                             desc_push,
    output logic                             desc_ready,
    input  logic [qie_pkg::QIE_DIM_BITS-1:0] width,
    input  logic [qie_pkg::QIE_DIM_BITS-1:0] height,
    output logic                             byte_valid,
    input  logic                             byte_stall,
    output logic [7:0]                       out_byte,
    output logic                             last_of_pixel,
    output logic                             end_of_image,
    output logic                             busy
);
    import qie_pkg::*;

    typedef enum logic [3:0] {
        PH_HDR   = 4'b0001,
        PH_RUN   = 4'b0010,
        PH_CHUNK = 4'b0100,
        PH_TAIL  = 4'b1000
    } phase_t;

    function automatic phase_t pick(input logic run, input logic chunk);
        if (run)
        begin
            return PH_RUN;
        end
        else if (chunk)
        begin
            return PH_CHUNK;
        end
        return PH_TAIL;
    endfunction

    qie_desc_t  desc_reg;
    logic       desc_valid_reg;
    phase_t     phase_reg;
    phase_t     phase_next;
    logic [3:0] cnt_reg;
    logic       byte_valid_reg;
    logic [7:0] byte_reg;
    logic       lop_reg;
    logic       eoi_reg;

    logic       advance;
    logic       done;
    logic       more;
    logic       final_byte;
    logic       has_chunk;
    logic [7:0] cur_byte;
    logic [7:0] hdr_byte;

    assign has_chunk  = desc_reg.chunk_len != '0;
    assign advance    = desc_valid_reg && (!byte_valid_reg || !byte_stall);
    assign final_byte = done && !more;
    assign desc_ready = !desc_valid_reg || (advance && final_byte);
    assign busy       = desc_valid_reg;

    always_comb
    begin
        unique case (cnt_reg)
            4'd0:    hdr_byte = 8'h71;
            4'd1:    hdr_byte = 8'h6F;
            4'd2:    hdr_byte = 8'h69;
            4'd3:    hdr_byte = 8'h66;
            4'd6:    hdr_byte = width[15:8];
            4'd7:    hdr_byte = width[7:0];
            4'd10:   hdr_byte = height[15:8];
            4'd11:   hdr_byte = height[7:0];
            4'd12:   hdr_byte = 8'h03;
            default: hdr_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        unique case (phase_reg)
            PH_HDR:
            begin
                cur_byte   = hdr_byte;
                done       = cnt_reg == 4'd13;
                more       = desc_reg.run || has_chunk || desc_reg.tail;
                phase_next = pick(desc_reg.run, has_chunk);
            end
            PH_RUN:
            begin
                cur_byte   = desc_reg.run_byte;
                done       = 1'b1;
                more       = has_chunk || desc_reg.tail;
                phase_next = pick(1'b0, has_chunk);
            end
            PH_CHUNK:
            begin
                cur_byte   = desc_reg.chunk[cnt_reg[1:0]];
                done       = cnt_reg == ({1'b0, desc_reg.chunk_len} - 4'd1);
                more       = desc_reg.tail;
                phase_next = PH_TAIL;
            end
            PH_TAIL:
            begin
                // seven zero bytes, then 01
                cur_byte   = (cnt_reg == 4'd7) ? 8'h01 : 8'h00;
                done       = cnt_reg == 4'd7;
                more       = 1'b0;
                phase_next = PH_TAIL;
            end
            default:
            begin
                cur_byte   = 8'h00;
                done       = 1'b1;
                more       = 1'b0;
                phase_next = PH_TAIL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_valid_reg <= 1'b0;
            phase_reg      <= PH_HDR;
            cnt_reg        <= '0;
        end
        else if (desc_push)
        begin
            desc_valid_reg <= 1'b1;
            phase_reg      <= desc_in.hdr ? PH_HDR
                                          : pick(desc_in.run, desc_in.chunk_len != '0);
            cnt_reg        <= '0;
        end
        else if (advance)
        begin
            if (final_byte)
            begin
                desc_valid_reg <= 1'b0;
            end
            else if (done)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_push)
        begin
            desc_reg <= desc_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            byte_valid_reg <= 1'b1;
        end
        else if (!byte_stall)
        begin
            byte_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg <= cur_byte;
            lop_reg  <= final_byte;
            eoi_reg  <= final_byte && (phase_reg == PH_TAIL);
        end
    end

    assign byte_valid    = byte_valid_reg;
    assign out_byte      = byte_reg;
    assign last_of_pixel = lop_reg;
    assign end_of_image  = eoi_reg;

endmodule

### rtl/qoi_image_encoder_top.sv
// QOI RGB encoder: one byte per cycle out while byte_stall is low. A pixel causes
// 1 to 4 bytes for its chunk, +1 run flush, +14 header, +8 end marker; or none.
// A transferred pixel passes the pixel stage, descriptor and output byte registers before its first byte is out.
// The byte output sets the pace; the pixel stage takes a new pixel as its current one moves on.
// Reset clears control, counters, previous pixel and all index valid bits at once;
// no clearing pass. Width and height registers reset to 1.
module qoi_image_encoder_top #(
    parameter int COORD_BITS = qie_pkg::QIE_COORD_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   pixel_valid,
    output logic                                   pixel_stall,
    input  logic [7:0]                             red,
    input  logic [7:0]                             green,
    input  logic [7:0]                             blue,
    output logic                                   byte_valid,
    input  logic                                   byte_stall,
    output logic [7:0]                             out_byte,
    output logic                                   last_of_pixel,
    output logic                                   end_of_image,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [qie_pkg::QIE_CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [qie_pkg::QIE_DIM_BITS-1:0]       cfg_data
);
    import qie_pkg::*;

    logic [QIE_DIM_BITS-1:0]   width_reg;
    logic [QIE_DIM_BITS-1:0]   height_reg;

    logic                      rd_en;
    logic [QIE_HASH_BITS-1:0]  rd_addr;
    logic [QIE_PIXEL_BITS-1:0] rd_data;
    logic                      wr_en;
    logic [QIE_HASH_BITS-1:0]  wr_addr;
    logic [QIE_PIXEL_BITS-1:0] wr_data;
    qie_desc_t                 desc;
    logic                      desc_push;
    logic                      desc_ready;
    logic                      coder_busy;
    logic                      sender_busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= QIE_DIM_BITS'(1);
            height_reg <= QIE_DIM_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == QIE_REG_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else if (cfg_index == QIE_REG_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    qie_index_ram u_index_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    qie_pixel_coder #(
        .COORD_BITS (COORD_BITS)
    ) u_pixel_coder (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .width       (width_reg),
        .height      (height_reg),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .desc        (desc),
        .desc_push   (desc_push),
        .desc_ready  (desc_ready),
        .busy        (coder_busy)
    );

    qie_byte_sender u_byte_sender (
        .clk           (clk),
        .rst_n         (rst_n),
        .desc_in       (desc),
        .desc_push     (desc_push),
        .desc_ready    (desc_ready),
        .width         (width_reg),
        .height        (height_reg),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .out_byte      (out_byte),
        .last_of_pixel (last_of_pixel),
        .end_of_image  (end_of_image),
        .busy          (sender_busy)
    );

    // End marker closes with 01 and always ends its pixel
    a_eoi_byte: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && end_of_image |-> last_of_pixel && (out_byte == 8'h01))
        else $error("end of image flag on a wrong byte");

    // A byte that does not end its pixel leaves more work queued
    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !last_of_pixel |-> sender_busy)
        else $error("pixel bytes cut short");

    // Input is held back only while a pixel sits in the coder
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> coder_busy && !desc_ready)
        else $error("pixel stall without a waiting pixel");

endmodule
